FILE: rtl/core/fll_pkg.sv
// ----------------------------------------------------------------------------
// fll_pkg: shared types and constants of the flat Lambert lighting block
// Register indexes, command codes, fixed levels and pipeline sideband records.
// ----------------------------------------------------------------------------
package fll_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_LIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SHADE = 1'b1;

  // levels in Q1.14
  localparam logic [14:0] LVL_ONE = 15'd16384;
  localparam logic [14:0] LVL_MIN = 15'd3277;

  // closeness = CLOSE_NUM / (CLOSE_BIAS + dist^2), 100 * 2^30 and 100 * 2^16
  localparam int unsigned CLOSE_NUM_W = 37;
  localparam logic [CLOSE_NUM_W-1:0] CLOSE_NUM = 37'd107374182400;
  localparam logic [22:0] CLOSE_BIAS = 23'd6553600;

  localparam int unsigned DEN_W    = 50;  // closeness divisor
  localparam int unsigned QUO_W    = 15;  // closeness and cosine quotients
  localparam int unsigned NNDD_W   = 60;  // |n|^2 * |d|^2 of scaled vectors
  localparam int unsigned ROOT_W   = NNDD_W / 2;
  localparam int unsigned DOT_W    = 30;  // scaled dot product magnitude
  localparam int unsigned COS_NUM_W = DOT_W + 14;

  // per-transaction data that rides along with every light operation
  typedef struct packed {
    logic        light;     // carries a light contribution
    logic        first;     // first operation of a shade transaction
    logic        last;      // last operation of a shade transaction
    logic        self_lit;
    logic [15:0] ambient;
    logic [15:0] strength;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } fll_meta_t;

  // into the closeness divider
  typedef struct packed {
    logic              zero;
    logic              neg;
    logic [DOT_W-1:0]  dot_mag;
    logic [NNDD_W-1:0] nndd;
    fll_meta_t         meta;
  } fll_sb1_t;

  // into the square root
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [DOT_W-1:0] dot_mag;
    logic [QUO_W-1:0] close;
    fll_meta_t        meta;
  } fll_sb2_t;

  // into the cosine divider
  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [QUO_W-1:0] close;
    fll_meta_t        meta;
  } fll_sb3_t;

endpackage

FILE: rtl/core/fll_div_pipe.sv
// ----------------------------------------------------------------------------
// fll_div_pipe: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module fll_div_pipe #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 50,
  parameter int unsigned QW = 15,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] sb_o
);

  localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_q   [QW];
  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [SW-1:0] sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] sb_in;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_tail
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    // divisor aligned to this quotient bit
    assign trial = RW'(den_in) << (QW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    // subtract when it fits, set the quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          quo_q[k] <= quo_in | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign sb_o    = sb_q[QW-1];

endmodule

FILE: rtl/core/fll_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// fll_isqrt_pipe: pipelined floor square root
// One root bit per stage, remainder kept as value minus root squared.
// ----------------------------------------------------------------------------
module fll_isqrt_pipe #(
  parameter int unsigned VW = 60,
  parameter int unsigned SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [VW-1:0]   val_i,
  input  logic [SW-1:0]   sb_i,
  output logic            valid_o,
  output logic [VW/2-1:0] root_o,
  output logic [SW-1:0]   sb_o
);

  localparam int unsigned RTW = VW / 2;
  localparam int unsigned TW  = VW + 2;

  logic           v_q    [RTW];
  logic [TW-1:0]  rem_q  [RTW];
  logic [RTW-1:0] root_q [RTW];
  logic [SW-1:0]  sb_q   [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    localparam int unsigned BIT = RTW - 1 - k;
    logic           v_in;
    logic [TW-1:0]  rem_in;
    logic [RTW-1:0] root_in;
    logic [SW-1:0]  sb_in;
    logic [TW-1:0]  trial;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = TW'(val_i);
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_tail
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // growth of root^2 when this bit is set
    assign trial = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[k] <= sb_in;
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (RTW'(1) << BIT);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[RTW-1];
  assign root_o  = root_q[RTW-1];
  assign sb_o    = sb_q[RTW-1];

endmodule

FILE: rtl/core/fll_front.sv
// ----------------------------------------------------------------------------
// fll_front: light table, issue sequencer and vector preparation stages
// Issues one light operation per cycle unless stalled and scales normal and light vector.
// ----------------------------------------------------------------------------
module fll_front #(
  parameter int unsigned MAX_LIGHTS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [1:0]           light_slot_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  logic signed [31:0]   norm_x_i,
  input  logic signed [31:0]   norm_y_i,
  input  logic signed [31:0]   norm_z_i,
  input  logic [15:0]          light_strength_i,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  input  logic [15:0]          ambient_i,
  input  logic                 self_lit_i,
  input  logic [2:0]           active_i,
  output logic                 valid_o,
  output logic [fll_pkg::DEN_W-1:0] den_o,
  output fll_pkg::fll_sb1_t    sb_o
);

  import fll_pkg::*;

  localparam int unsigned IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CW = $clog2(MAX_LIGHTS + 1);

  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] b;
    b = '0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) b = 6'(k + 1);
    end
    return b;
  endfunction

  function automatic logic signed [14:0] scale(input logic [31:0] a, input logic [5:0] b,
                                               input logic neg);
    logic [31:0] s;
    logic [14:0] m;
    if (b > 6'd14) s = a >> (b - 6'd14);
    else s = a << (6'd14 - b);
    m = {1'b0, s[13:0]};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // light table
  logic signed [31:0] tab_x_q [MAX_LIGHTS];
  logic signed [31:0] tab_y_q [MAX_LIGHTS];
  logic signed [31:0] tab_z_q [MAX_LIGHTS];
  logic [15:0]        tab_l_q [MAX_LIGHTS];

  // held shade transaction
  logic               pend_q;
  logic [IW-1:0]      li_q;
  logic [CW-1:0]      n_q;
  logic               lit_q;
  logic               self_q;
  logic [15:0]        amb_q;
  logic signed [31:0] hp_q [3];
  logic signed [31:0] hn_q [3];
  logic [7:0]         hr_q, hg_q, hb_q;

  logic          issue_last;
  logic          accept;
  logic          shade_lit;
  logic [CW-1:0] cnt_in;

  assign issue_last = pend_q && ((CW'(li_q) + CW'(1)) == n_q);
  assign in_ready_o = en_i && (!pend_q || issue_last);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_in     = (32'(active_i) > MAX_LIGHTS) ? CW'(MAX_LIGHTS) : CW'(active_i);
  assign shade_lit  = !self_lit_i && (cnt_in != '0);

  // write a light entry on a load transaction
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_LOAD && 32'(light_slot_i) < MAX_LIGHTS) begin
      tab_x_q[IW'(light_slot_i)] <= pos_x_i;
      tab_y_q[IW'(light_slot_i)] <= pos_y_i;
      tab_z_q[IW'(light_slot_i)] <= pos_z_i;
      tab_l_q[IW'(light_slot_i)] <= light_strength_i;
    end
  end

  // hold the shade transaction while its operations issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept && cmd_i == CMD_SHADE) begin
      pend_q <= 1'b1;
    end else if (en_i && issue_last) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_SHADE) begin
      li_q   <= '0;
      n_q    <= shade_lit ? cnt_in : CW'(1);
      lit_q  <= shade_lit;
      self_q <= self_lit_i;
      amb_q  <= ambient_i;
      hp_q[0] <= pos_x_i;
      hp_q[1] <= pos_y_i;
      hp_q[2] <= pos_z_i;
      hn_q[0] <= norm_x_i;
      hn_q[1] <= norm_y_i;
      hn_q[2] <= norm_z_i;
      hr_q   <= red_in_i;
      hg_q   <= green_in_i;
      hb_q   <= blue_in_i;
    end else if (en_i && pend_q) begin
      li_q <= li_q + IW'(1);
    end
  end

  // stage registers
  logic               s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  fll_meta_t          s1_m_q, s2_m_q, s3_m_q, s4_m_q, s5_m_q, s6_m_q, s7_m_q;
  logic signed [32:0] s1_d_q [3];
  logic signed [31:0] s1_n_q [3];
  logic [31:0]        s2_dm_q [3], s2_nm_q [3], s3_dm_q [3], s3_nm_q [3];
  logic [31:0]        s4_dm_q [3], s4_nm_q [3];
  logic               s2_dn_q [3], s2_nn_q [3], s3_dn_q [3], s3_nn_q [3];
  logic               s4_dn_q [3], s4_nn_q [3];
  logic [23:0]        s2_e_q [3];
  logic [31:0]        s3_dmax_q, s3_nmax_q;
  logic [47:0]        s3_esq_q [3];
  logic [5:0]         s4_db_q, s4_nb_q;
  logic [DEN_W-1:0]   s4_den_q, s5_den_q, s6_den_q, s7_den_q;
  logic               s4_z_q, s5_z_q, s6_z_q, s7_z_q;
  logic signed [14:0] s5_ds_q [3], s5_ns_q [3];
  logic               s6_neg_q, s7_neg_q;
  logic [DOT_W-1:0]   s6_dot_q, s7_dot_q;
  logic [29:0]        s6_nn_q, s6_dd_q;
  logic [NNDD_W-1:0]  s7_nndd_q;

  // issue stage contents
  fll_meta_t s1_m_d;
  always_comb begin
    s1_m_d.light    = lit_q;
    s1_m_d.first    = (li_q == '0);
    s1_m_d.last     = issue_last;
    s1_m_d.self_lit = self_q;
    s1_m_d.ambient  = amb_q;
    s1_m_d.strength = tab_l_q[li_q];
    s1_m_d.red      = hr_q;
    s1_m_d.green    = hg_q;
    s1_m_d.blue     = hb_q;
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= pend_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  // light minus vertex, magnitudes, magnitude ORs, scaling, products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_m_q <= s1_m_d;
      s1_d_q[0] <= 33'(tab_x_q[li_q]) - 33'(hp_q[0]);
      s1_d_q[1] <= 33'(tab_y_q[li_q]) - 33'(hp_q[1]);
      s1_d_q[2] <= 33'(tab_z_q[li_q]) - 33'(hp_q[2]);
      for (int k = 0; k < 3; k++) s1_n_q[k] <= hn_q[k];

      s2_m_q <= s1_m_q;
      for (int k = 0; k < 3; k++) begin
        s2_dn_q[k] <= s1_d_q[k][32];
        s2_nn_q[k] <= s1_n_q[k][31];
        s2_dm_q[k] <= 32'(s1_d_q[k][32] ? -s1_d_q[k] : s1_d_q[k]);
        s2_nm_q[k] <= s1_n_q[k][31] ? 32'(-s1_n_q[k]) : 32'(s1_n_q[k]);
        s2_e_q[k]  <= s1_d_q[k][32] ? 24'((-s1_d_q[k]) >>> 8) : s1_d_q[k][31:8];
      end

      s3_m_q <= s2_m_q;
      for (int k = 0; k < 3; k++) begin
        s3_dm_q[k]  <= s2_dm_q[k];
        s3_nm_q[k]  <= s2_nm_q[k];
        s3_dn_q[k]  <= s2_dn_q[k];
        s3_nn_q[k]  <= s2_nn_q[k];
        s3_esq_q[k] <= 48'(s2_e_q[k]) * 48'(s2_e_q[k]);
      end
      s3_dmax_q <= (s2_dm_q[0] | s2_dm_q[1] | s2_dm_q[2]);
      s3_nmax_q <= (s2_nm_q[0] | s2_nm_q[1] | s2_nm_q[2]);

      s4_m_q <= s3_m_q;
      for (int k = 0; k < 3; k++) begin
        s4_dm_q[k] <= s3_dm_q[k];
        s4_nm_q[k] <= s3_nm_q[k];
        s4_dn_q[k] <= s3_dn_q[k];
        s4_nn_q[k] <= s3_nn_q[k];
      end
      s4_db_q  <= bit_len(s3_dmax_q);
      s4_nb_q  <= bit_len(s3_nmax_q);
      s4_z_q   <= (s3_dmax_q == '0) || (s3_nmax_q == '0);
      s4_den_q <= DEN_W'(CLOSE_BIAS) + DEN_W'(s3_esq_q[0]) + DEN_W'(s3_esq_q[1])
                  + DEN_W'(s3_esq_q[2]);

      s5_m_q   <= s4_m_q;
      s5_z_q   <= s4_z_q;
      s5_den_q <= s4_den_q;
      for (int k = 0; k < 3; k++) begin
        s5_ds_q[k] <= scale(s4_dm_q[k], s4_db_q, s4_dn_q[k]);
        s5_ns_q[k] <= scale(s4_nm_q[k], s4_nb_q, s4_nn_q[k]);
      end

      s6_m_q   <= s5_m_q;
      s6_z_q   <= s5_z_q;
      s6_den_q <= s5_den_q;
      begin : b_dot
        logic signed [31:0] dot;
        dot = 32'(s5_ds_q[0] * s5_ns_q[0]) + 32'(s5_ds_q[1] * s5_ns_q[1])
              + 32'(s5_ds_q[2] * s5_ns_q[2]);
        s6_neg_q <= dot[31];
        s6_dot_q <= DOT_W'(dot[31] ? -dot : dot);
      end
      s6_nn_q <= 30'(s5_ns_q[0] * s5_ns_q[0]) + 30'(s5_ns_q[1] * s5_ns_q[1])
                 + 30'(s5_ns_q[2] * s5_ns_q[2]);
      s6_dd_q <= 30'(s5_ds_q[0] * s5_ds_q[0]) + 30'(s5_ds_q[1] * s5_ds_q[1])
                 + 30'(s5_ds_q[2] * s5_ds_q[2]);

      s7_m_q    <= s6_m_q;
      s7_z_q    <= s6_z_q;
      s7_den_q  <= s6_den_q;
      s7_neg_q  <= s6_neg_q;
      s7_dot_q  <= s6_dot_q;
      s7_nndd_q <= NNDD_W'(s6_nn_q) * NNDD_W'(s6_dd_q);
    end
  end

  assign valid_o = s7_v_q;
  assign den_o   = s7_den_q;
  always_comb begin
    sb_o.zero    = s7_z_q;
    sb_o.neg     = s7_neg_q;
    sb_o.dot_mag = s7_dot_q;
    sb_o.nndd    = s7_nndd_q;
    sb_o.meta    = s7_m_q;
  end

endmodule

FILE: rtl/core/fll_back.sv
// ----------------------------------------------------------------------------
// fll_back: light term, accumulation, clamp and colour scaling
// Sums light terms per shade transaction and holds the result register.
// ----------------------------------------------------------------------------
module fll_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [fll_pkg::QUO_W-1:0] cos_i,
  input  fll_pkg::fll_sb3_t        sb_i,
  output logic                     out_valid_o,
  output logic [7:0]               red_out_o,
  output logic [7:0]               green_out_o,
  output logic [7:0]               blue_out_o,
  output logic [14:0]              lit_level_o
);

  import fll_pkg::*;

  logic               b1_v_q, b2_v_q, b3_v_q, out_v_q;
  fll_meta_t          b1_m_q, b2_m_q, b3_m_q;
  logic               b1_neg_q;
  logic [QUO_W-1:0]   b1_close_q;
  logic [30:0]        b1_p_q;
  logic signed [18:0] b2_term_q;
  logic signed [23:0] acc_q, b3_lvl_q;
  logic [7:0]         r_q, g_q, bl_q;
  logic [14:0]        lvl_q;

  logic [QUO_W-1:0]   cos_c;
  logic [45:0]        p2;
  logic signed [23:0] sum;
  logic [14:0]        lvl_c;

  // clamp the cosine, drop it for zero vectors and pure tokens
  assign cos_c = (!sb_i.meta.light || sb_i.zero) ? '0 :
                 (cos_i > LVL_ONE) ? LVL_ONE : cos_i;
  assign p2    = 46'(b1_p_q) * 46'(b1_close_q);
  assign sum   = (b2_m_q.first ? 24'($signed({1'b0, b2_m_q.ambient})) : acc_q)
                 + 24'(b2_term_q);

  always_comb begin
    if (b3_m_q.self_lit) lvl_c = LVL_ONE;
    else if (b3_lvl_q > 24'($signed({1'b0, LVL_ONE}))) lvl_c = LVL_ONE;
    else if (b3_lvl_q < 24'($signed({1'b0, LVL_MIN}))) lvl_c = LVL_MIN;
    else lvl_c = b3_lvl_q[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      b1_v_q  <= valid_i;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q && b2_m_q.last;
      out_v_q <= b3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // strength times cosine
      b1_m_q     <= sb_i.meta;
      b1_neg_q   <= sb_i.neg;
      b1_close_q <= sb_i.close;
      b1_p_q     <= 31'(sb_i.meta.strength) * 31'(cos_c);
      // times closeness, signed term; a token adds no term
      b2_m_q     <= b1_m_q;
      if (!b1_m_q.light) begin
        b2_term_q <= '0;
      end else begin
        b2_term_q <= b1_neg_q ? -$signed({1'b0, p2[45:28]}) : $signed({1'b0, p2[45:28]});
      end
      // running sum per shade transaction
      if (b2_v_q) acc_q <= sum;
      b3_m_q   <= b2_m_q;
      b3_lvl_q <= sum;
      // colour scaling into the result register
      if (b3_v_q) begin
        lvl_q <= lvl_c;
        r_q   <= b3_m_q.self_lit ? b3_m_q.red   : 8'((23'(b3_m_q.red)   * 23'(lvl_c)) >> 14);
        g_q   <= b3_m_q.self_lit ? b3_m_q.green : 8'((23'(b3_m_q.green) * 23'(lvl_c)) >> 14);
        bl_q  <= b3_m_q.self_lit ? b3_m_q.blue  : 8'((23'(b3_m_q.blue)  * 23'(lvl_c)) >> 14);
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign red_out_o   = r_q;
  assign green_out_o = g_q;
  assign blue_out_o  = bl_q;
  assign lit_level_o = lvl_q;

endmodule

FILE: rtl/core/flat_lambert_lighting.sv
// ----------------------------------------------------------------------------
// flat_lambert_lighting: flat per-polygon Lambert lighting with attenuation
//
//   channel  signals                          handshake
//   input    cmd, slot, pos, norm, strength,  in_valid_i / in_ready_o
//            red/green/blue in
//   result   red/green/blue out, lit_level    out_valid_o / out_ready_i
//   config   cfg_idx_i, cfg_data_i            cfg_we_i, no wait
//
// A shade transaction issues one light operation per cycle unless the pipe is
// frozen: one per active light up to MAX_LIGHTS, or one token when none is
// active or self-lit is set. Results pass 7 prep stages, a 15-stage closeness
// divider, 30-stage square root, 15-stage cosine divider and 4 tail stages.
// Reset clears valid bits and configuration; the light table is not cleared.
// A full, untaken result register freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module flat_lambert_lighting #(
  parameter int unsigned MAX_LIGHTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [1:0]                          light_slot_i,
  input  logic signed [31:0]                  pos_x_i,
  input  logic signed [31:0]                  pos_y_i,
  input  logic signed [31:0]                  pos_z_i,
  input  logic signed [31:0]                  norm_x_i,
  input  logic signed [31:0]                  norm_y_i,
  input  logic signed [31:0]                  norm_z_i,
  input  logic [15:0]                         light_strength_i,
  input  logic [7:0]                          red_in_i,
  input  logic [7:0]                          green_in_i,
  input  logic [7:0]                          blue_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          red_out_o,
  output logic [7:0]                          green_out_o,
  output logic [7:0]                          blue_out_o,
  output logic [14:0]                         lit_level_o,
  input  logic                                cfg_we_i,
  input  logic [fll_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fll_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import fll_pkg::*;

  logic        en;
  logic [15:0] ambient_q;
  logic        self_lit_q;
  logic [2:0]  active_q;

  // advance the pipeline unless the result register is stalled
  assign en = !out_valid_o || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q  <= '0;
      self_lit_q <= 1'b0;
      active_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AMBIENT:  ambient_q  <= cfg_data_i;
        CFG_SELF_LIT: self_lit_q <= cfg_data_i[0];
        CFG_ACTIVE:   active_q   <= cfg_data_i[2:0];
        default:      ;
      endcase
    end
  end

  logic             f_v;
  logic [DEN_W-1:0] f_den;
  fll_sb1_t         f_sb;

  fll_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .in_valid_i, .in_ready_o,
    .cmd_i, .light_slot_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .norm_x_i, .norm_y_i, .norm_z_i, .light_strength_i,
    .red_in_i, .green_in_i, .blue_in_i,
    .ambient_i(ambient_q), .self_lit_i(self_lit_q), .active_i(active_q),
    .valid_o(f_v), .den_o(f_den), .sb_o(f_sb)
  );

  // closeness division
  logic                  c_v;
  logic [QUO_W-1:0]      c_quo;
  logic [$bits(fll_sb1_t)-1:0] c_sbv;
  fll_sb1_t              c_sb;
  fll_sb2_t              q_sb_in;

  fll_div_pipe #(.NW(CLOSE_NUM_W), .DW(DEN_W), .QW(QUO_W), .SW($bits(fll_sb1_t))) u_close (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v), .num_i(CLOSE_NUM), .den_i(f_den),
    .sb_i(f_sb), .valid_o(c_v), .quo_o(c_quo), .sb_o(c_sbv)
  );

  assign c_sb = fll_sb1_t'(c_sbv);
  always_comb begin
    q_sb_in.zero    = c_sb.zero;
    q_sb_in.neg     = c_sb.neg;
    q_sb_in.dot_mag = c_sb.dot_mag;
    q_sb_in.close   = c_quo;
    q_sb_in.meta    = c_sb.meta;
  end

  // root of |n|^2 |d|^2
  logic                  r_v;
  logic [ROOT_W-1:0]     r_root;
  logic [$bits(fll_sb2_t)-1:0] r_sbv;
  fll_sb2_t              r_sb;
  fll_sb3_t              d_sb_in;

  fll_isqrt_pipe #(.VW(NNDD_W), .SW($bits(fll_sb2_t))) u_root (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_v), .val_i(c_sb.nndd), .sb_i(q_sb_in),
    .valid_o(r_v), .root_o(r_root), .sb_o(r_sbv)
  );

  assign r_sb = fll_sb2_t'(r_sbv);
  always_comb begin
    d_sb_in.zero  = r_sb.zero;
    d_sb_in.neg   = r_sb.neg;
    d_sb_in.close = r_sb.close;
    d_sb_in.meta  = r_sb.meta;
  end

  // cosine division
  logic                  k_v;
  logic [QUO_W-1:0]      k_quo;
  logic [$bits(fll_sb3_t)-1:0] k_sbv;

  fll_div_pipe #(.NW(COS_NUM_W), .DW(ROOT_W), .QW(QUO_W), .SW($bits(fll_sb3_t))) u_cos (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r_v), .num_i({r_sb.dot_mag, 14'd0}),
    .den_i(r_root), .sb_i(d_sb_in), .valid_o(k_v), .quo_o(k_quo), .sb_o(k_sbv)
  );

  fll_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k_v), .cos_i(k_quo), .sb_i(fll_sb3_t'(k_sbv)),
    .out_valid_o, .red_out_o, .green_out_o, .blue_out_o, .lit_level_o
  );

endmodule

FILE: rtl/core/fll_checker.sv
// ----------------------------------------------------------------------------
// fll_checker: port-level checks of the lighting block
// Result hold under stall, level range and reset behavior.
// ----------------------------------------------------------------------------
module fll_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_out_o,
  input logic [14:0] lit_level_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lit_level_o) && $stable(red_out_o))
    else $error("stalled result changed");

  // keep the level at or below one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lit_level_o <= 15'd16384)
    else $error("level above one");

  // keep the level at or above the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lit_level_o >= 15'd3277)
    else $error("level below floor");

  // drop results once reset has been seen
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result during reset");

endmodule

bind flat_lambert_lighting fll_checker u_fll_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the flat Lambert lighting block
// Loads the light table, shades faces under several register settings and
// compares every result with an in-bench fixed-point lighting predictor.
// Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fll_pkg::*;

  localparam int NUM_LIGHTS  = 4;
  localparam int LEVEL_ONE   = 16384;
  localparam int LEVEL_FLOOR = 3277;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic              cmd;
    logic [1:0]        slot;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] nx, ny, nz;
    logic [15:0]       strength;
    logic [7:0]        red, green, blue;
  } face_item_t;

  typedef struct {
    logic [7:0]  red, green, blue;
    logic [14:0] level;
  } lit_color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = CMD_LOAD;
  logic [1:0] light_slot_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] norm_x_i = '0, norm_y_i = '0, norm_z_i = '0;
  logic [15:0] light_strength_i = '0;
  logic [7:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] red_out_o, green_out_o, blue_out_o;
  logic [14:0] lit_level_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_AMBIENT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state
  longint     lamp_x[NUM_LIGHTS], lamp_y[NUM_LIGHTS], lamp_z[NUM_LIGHTS];
  longint     lamp_str[NUM_LIGHTS];
  int         ambient_q;
  bit         self_lit_q;
  int         active_q;
  lit_color_t pending_colors[$];
  int         fail_count = 0;
  bit         calm = 1'b0;
  longint     cycle_count = 0;

  flat_lambert_lighting dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result stall pattern
  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int bit_length(longint unsigned v);
    int b = 0;
    while (v != 0) begin
      v >>= 1;
      b++;
    end
    return b;
  endfunction

  // scale so the largest magnitude lands in [2^13, 2^14)
  function automatic bit block_scale(input longint v[3], output longint o[3]);
    longint unsigned m = 0;
    longint unsigned a;
    int b;
    for (int k = 0; k < 3; k++) if (mag(v[k]) > m) m = mag(v[k]);
    if (m == 0) return 1'b0;
    b = bit_length(m);
    for (int k = 0; k < 3; k++) begin
      a = mag(v[k]);
      if (b > 14) a >>= (b - 14);
      else a <<= (14 - b);
      o[k] = v[k] < 0 ? -longint'(a) : longint'(a);
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint face_cosine(input longint n[3], input longint d[3]);
    longint ns[3], ds[3];
    longint dot = 0;
    longint unsigned nn = 0, dd = 0, r, q;
    if (!block_scale(n, ns) || !block_scale(d, ds)) return 0;
    for (int k = 0; k < 3; k++) begin
      dot += ns[k] * ds[k];
      nn += ns[k] * ns[k];
      dd += ds[k] * ds[k];
    end
    r = floor_sqrt(nn * dd);
    if (r == 0) return 0;
    q = (mag(dot) * LEVEL_ONE) / r;
    if (q > LEVEL_ONE) q = LEVEL_ONE;
    return dot < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned distance_falloff(input longint d[3]);
    longint unsigned s = 0, e;
    for (int k = 0; k < 3; k++) begin
      e = mag(d[k]) >> 8;
      s += e * e;
    end
    return (64'd100 << 30) / ((64'd100 << 16) + s);
  endfunction

  // update the light table or work out the lit color of one face
  function automatic bit light_face(input face_item_t it, output lit_color_t lc);
    longint n[3], d[3], c, lvl;
    longint unsigned t;
    int cnt;
    if (it.cmd == CMD_LOAD) begin
      lamp_x[it.slot] = it.px;
      lamp_y[it.slot] = it.py;
      lamp_z[it.slot] = it.pz;
      lamp_str[it.slot] = it.strength;
      return 1'b0;
    end
    if (self_lit_q) begin
      lc = '{it.red, it.green, it.blue, 15'(LEVEL_ONE)};
      return 1'b1;
    end
    n = '{it.nx, it.ny, it.nz};
    cnt = active_q > NUM_LIGHTS ? NUM_LIGHTS : active_q;
    lvl = ambient_q;
    for (int i = 0; i < cnt; i++) begin
      d = '{lamp_x[i] - it.px, lamp_y[i] - it.py, lamp_z[i] - it.pz};
      c = face_cosine(n, d);
      t = (longint'(lamp_str[i]) * mag(c) * distance_falloff(d)) >> 28;
      lvl += c < 0 ? -longint'(t) : longint'(t);
    end
    if (lvl > LEVEL_ONE) lvl = LEVEL_ONE;
    if (lvl < LEVEL_FLOOR) lvl = LEVEL_FLOOR;
    lc.red   = 8'((longint'(it.red) * lvl) >> 14);
    lc.green = 8'((longint'(it.green) * lvl) >> 14);
    lc.blue  = 8'((longint'(it.blue) * lvl) >> 14);
    lc.level = 15'(lvl);
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk_i) begin
    lit_color_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d level %0d",
               red_out_o, green_out_o, blue_out_o, lit_level_o);
        fail_count++;
      end else begin
        want = pending_colors.pop_front();
        if (red_out_o !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, red_out_o);
          fail_count++;
        end
        if (green_out_o !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, green_out_o);
          fail_count++;
        end
        if (blue_out_o !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, blue_out_o);
          fail_count++;
        end
        if (lit_level_o !== want.level) begin
          $error("lit_level: expected %0d, got %0d", want.level, lit_level_o);
          fail_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  task automatic send_item(input face_item_t it);
    int gap;
    lit_color_t lc;
    gap = (!calm && $urandom_range(99) < 24) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_i <= it.cmd;
    light_slot_i <= it.slot;
    pos_x_i <= it.px;
    pos_y_i <= it.py;
    pos_z_i <= it.pz;
    norm_x_i <= it.nx;
    norm_y_i <= it.ny;
    norm_z_i <= it.nz;
    light_strength_i <= it.strength;
    red_in_i <= it.red;
    green_in_i <= it.green;
    blue_in_i <= it.blue;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (light_face(it, lc)) pending_colors.insert(pending_colors.size(), lc);
  endtask

  // stop sending, drain every expected result, then idle before returning
  task automatic drain_block();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain_block();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      CFG_AMBIENT:  ambient_q = value & 16'hFFFF;
      CFG_SELF_LIT: self_lit_q = value & 1;
      CFG_ACTIVE:   active_q = value & 7;
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------ item helpers
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'sd0;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
  endfunction

  function automatic face_item_t load_item(int slot, logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, int strength);
    face_item_t it;
    it = '{CMD_LOAD, 2'(slot), x, y, z, $urandom, $urandom, $urandom,
           16'(strength), 8'($urandom), 8'($urandom), 8'($urandom)};
    return it;
  endfunction

  function automatic face_item_t shade_item(logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] nx,
      logic signed [31:0] ny, logic signed [31:0] nz, int r, int g, int b);
    face_item_t it;
    it = '{CMD_SHADE, 2'($urandom), x, y, z, nx, ny, nz, 16'($urandom),
           8'(r), 8'(g), 8'(b)};
    return it;
  endfunction

  function automatic face_item_t random_item();
    if ($urandom_range(99) < 15)
      return load_item($urandom_range(3), rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(1) ? $urandom : $urandom_range(0, 20000));
    return shade_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_defaults();
    // no lights, zero ambient: level floors at 0.2
    send_item(shade_item(0, 0, 0, 65536, 0, 0, 255, 128, 1));
    send_item(shade_item(0, 0, 0, 0, 0, 0, 0, 255, 77));
  endtask

  task automatic test_light_table();
    send_item(load_item(0, 0, 0, 32'sd655360, 16384));
    send_item(load_item(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 65535));
    send_item(load_item(2, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0));
    send_item(load_item(3, 32'sd65536, 32'sd0, 32'sd0, 8192));
  endtask

  task automatic test_corner_faces();
    write_reg(CFG_ACTIVE, 4);
    write_reg(CFG_AMBIENT, 0);
    // facing light 0, then back to it (signed cosine subtracts)
    send_item(shade_item(0, 0, 0, 0, 0, 65536, 255, 255, 255));
    send_item(shade_item(0, 0, 0, 0, 0, -65536, 255, 255, 255));
    // zero normal, and vertex sitting on a light
    send_item(shade_item(0, 0, 0, 0, 0, 0, 200, 100, 50));
    send_item(shade_item(0, 0, 32'sd655360, 65536, 65536, 65536, 255, 0, 255));
    // extreme coordinates and normals
    send_item(shade_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 255, 0));
    send_item(shade_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 255, 0, 255));
    send_item(shade_item(-1, -1, -1, 1, 1, 1, 1, 1, 1));
  endtask

  task automatic test_settings();
    write_reg(CFG_AMBIENT, 65535);
    send_item(shade_item(0, 0, 0, 0, 0, -65536, 255, 255, 255));
    write_reg(CFG_ACTIVE, 7);  // saturates to the table size
    send_item(shade_item(0, 0, 0, 0, 65536, 0, 255, 17, 200));
    write_reg(CFG_ACTIVE, 5);
    write_reg(CFG_AMBIENT, 3000);
    send_item(shade_item(0, 0, 0, 0, 0, 65536, 255, 255, 255));
    write_reg(CFG_SELF_LIT, 1);
    send_item(shade_item(5, 5, 5, 0, 0, 0, 255, 0, 170));
    send_item(shade_item(5, 5, 5, 0, 0, 0, 85, 255, 0));
    write_reg(CFG_SELF_LIT, 0);
    write_reg(3, 16'hFFFF);  // unknown index, no effect
    write_reg(CFG_ACTIVE, 1);
    send_item(shade_item(0, 0, 0, 0, 0, 65536, 255, 255, 255));
  endtask

  task automatic test_random_traffic();
    int amb[6] = '{0, 8192, 16384, 65535, 2000, 12000};
    int act[6] = '{4, 2, 0, 1, 3, 6};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_AMBIENT, amb[ph]);
      write_reg(CFG_ACTIVE, act[ph]);
      write_reg(CFG_SELF_LIT, ph == 4);
      calm = (ph == 1);
      repeat (100) send_item(random_item());
      calm = 1'b0;
    end
  endtask

  initial begin
    ambient_q = 0;
    self_lit_q = 1'b0;
    active_q = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_defaults();
    test_light_table();
    test_corner_faces();
    test_settings();
    test_random_traffic();
    drain_block();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fll_pkg.sv
rtl/core/fll_div_pipe.sv
rtl/core/fll_isqrt_pipe.sv
rtl/core/fll_front.sv
rtl/core/fll_back.sv
rtl/core/flat_lambert_lighting.sv
rtl/core/fll_checker.sv
bench/tb_top.sv
